/* hw/rtl/ledfr_pkg.sv */
package ledfr_pkg;

  localparam logic [7:0] CHAN_FLOOR = 8'd5;

  localparam int PADDR_W = 5;

  localparam logic [PADDR_W-1:0] REG_SEG_START     = 5'h00;
  localparam logic [PADDR_W-1:0] REG_SEG_END       = 5'h04;
  localparam logic [PADDR_W-1:0] REG_ROTATE_DIR    = 5'h08;
  localparam logic [PADDR_W-1:0] REG_SPEED_DIV     = 5'h0C;
  localparam logic [PADDR_W-1:0] REG_ROTATE_ENABLE = 5'h10;

  typedef enum logic [1:0] {
    CMD_FILL = 2'd0,
    CMD_TICK = 2'd1,
    CMD_READ = 2'd2
  } cmd_e_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_ROT,
    ST_DRAIN,
    ST_WRAP,
    ST_READ,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic [6:0] seg_start;
    logic [6:0] seg_end;
    logic       rotate_dir;
    logic [7:0] speed_div;
    logic       rotate_enable;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  range_start;
    logic [6:0]  range_end;
    logic [23:0] fill_color;
    logic [6:0]  read_index;
  } cmd_word_t;

  typedef struct packed {
    logic        status;
    logic [23:0] pixel_color;
  } res_word_t;

  function automatic logic [23:0] drop_dim_channels(input logic [23:0] color);
    logic [23:0] fixed;
    fixed = color;
    for (int ch = 0; ch < 3; ch++) begin
      if (color[ch*8 +: 8] < CHAN_FLOOR) begin
        fixed[ch*8 +: 8] = 8'd0;
      end
    end
    return fixed;
  endfunction

endpackage

/* hw/rtl/ledfr_if.sv */
interface ledfr_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [6:0]  range_start;
  logic [6:0]  range_end;
  logic [23:0] fill_color;
  logic [6:0]  read_index;

  modport source (
    output valid, command, range_start, range_end, fill_color, read_index,
    input  ready
  );
  modport sink (
    input  valid, command, range_start, range_end, fill_color, read_index,
    output ready
  );
endinterface

interface ledfr_res_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [23:0] pixel_color;

  modport source (
    output valid, status, pixel_color,
    input  ready
  );
  modport sink (
    input  valid, status, pixel_color,
    output ready
  );
endinterface

/* hw/rtl/ledfr_pixel_mem.sv */
module ledfr_pixel_mem #(
  parameter int LED_COUNT = 128,
  localparam int AW = $clog2(LED_COUNT)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [23:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [23:0]   rdata
);

  logic [23:0] mem [LED_COUNT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* hw/rtl/ledfr_ctrl.sv */
module ledfr_ctrl #(
  parameter int LED_COUNT = 128,
  localparam int AW = $clog2(LED_COUNT)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  ledfr_pkg::cfg_t       cfg,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  ledfr_pkg::cmd_word_t  in_word,
  output logic                  out_valid,
  input  logic                  out_ready,
  output ledfr_pkg::res_word_t  out_word,
  output logic                  mem_we,
  output logic [AW-1:0]         mem_waddr,
  output logic [23:0]           mem_wdata,
  output logic                  mem_re,
  output logic [AW-1:0]         mem_raddr,
  input  logic [23:0]           mem_rdata
);

  ledfr_pkg::state_t state, state_next;

  logic [AW-1:0] ptr, ptr_next;
  logic [AW-1:0] last, last_next;
  logic [AW-1:0] wp, wp_next;
  logic          step_dn, step_dn_next;
  logic [1:0]    pipe_cnt, pipe_cnt_next;
  logic [23:0]   saved, saved_next;
  logic [23:0]   fill_c, fill_c_next;
  logic [7:0]    phase, phase_next;
  logic          res_status, res_status_next;
  logic          res_read, res_read_next;
  logic          out_load;

  logic [AW-1:0] ptr_step;
  logic [AW-1:0] wp_step;
  logic          ptr_last;
  logic [8:0]    phase_inc;
  logic          fill_ok;
  logic          seg_ok;

  // Address steppers: an incrementer/decrementer each for ptr and wp, and an end compare on ptr.
  assign ptr_step = step_dn ? ptr - AW'(1) : ptr + AW'(1);
  assign ptr_last = (ptr == last);
  assign wp_step  = step_dn ? wp - AW'(1) : wp + AW'(1);

  assign phase_inc = {1'b0, phase} + 9'd1;
  assign fill_ok   = (in_word.range_start < in_word.range_end) &&
                     (32'(in_word.range_end) < 32'(LED_COUNT));
  assign seg_ok    = (cfg.seg_end >= cfg.seg_start) &&
                     (32'(cfg.seg_end) < 32'(LED_COUNT));

  assign in_ready = (state == ledfr_pkg::ST_IDLE);

  always_comb begin
    state_next      = state;
    ptr_next        = ptr;
    last_next       = last;
    wp_next         = wp;
    step_dn_next    = step_dn;
    pipe_cnt_next   = pipe_cnt;
    saved_next      = saved;
    fill_c_next     = fill_c;
    phase_next      = phase;
    res_status_next = res_status;
    res_read_next   = res_read;
    out_load        = 1'b0;
    mem_we          = 1'b0;
    mem_waddr       = ptr;
    mem_wdata       = '0;
    mem_re          = 1'b0;
    mem_raddr       = ptr;

    case (state)
      ledfr_pkg::ST_CLEAR: begin
        mem_we = 1'b1;
        if (ptr_last) begin
          state_next = ledfr_pkg::ST_IDLE;
        end else begin
          ptr_next = ptr_step;
        end
      end

      ledfr_pkg::ST_IDLE: begin
        if (in_valid) begin
          res_status_next = 1'b0;
          res_read_next   = 1'b0;
          state_next      = ledfr_pkg::ST_RESULT;
          case (in_word.command)
            ledfr_pkg::CMD_FILL: begin
              if (fill_ok) begin
                ptr_next     = AW'(in_word.range_start);
                last_next    = AW'(in_word.range_end);
                step_dn_next = 1'b0;
                fill_c_next  = ledfr_pkg::drop_dim_channels(in_word.fill_color);
                state_next   = ledfr_pkg::ST_FILL;
              end else begin
                res_status_next = 1'b1;
              end
            end
            ledfr_pkg::CMD_TICK: begin
              if (cfg.rotate_enable) begin
                phase_next = (phase_inc >= {1'b0, cfg.speed_div}) ? 8'd0 : phase_inc[7:0];
                if (((cfg.speed_div == 8'd0) || (phase == 8'd0)) && seg_ok) begin
                  pipe_cnt_next = 2'd0;
                  state_next    = ledfr_pkg::ST_ROT;
                  if (cfg.rotate_dir) begin
                    ptr_next     = AW'(cfg.seg_start);
                    wp_next      = AW'(cfg.seg_start);
                    last_next    = AW'(cfg.seg_end);
                    step_dn_next = 1'b0;
                  end else begin
                    ptr_next     = AW'(cfg.seg_end);
                    wp_next      = AW'(cfg.seg_end);
                    last_next    = AW'(cfg.seg_start);
                    step_dn_next = 1'b1;
                  end
                end
              end
            end
            ledfr_pkg::CMD_READ: begin
              if (32'(in_word.read_index) < 32'(LED_COUNT)) begin
                ptr_next      = AW'(in_word.read_index);
                res_read_next = 1'b1;
                state_next    = ledfr_pkg::ST_READ;
              end
            end
            default: begin
            end
          endcase
        end
      end

      ledfr_pkg::ST_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = fill_c;
        if (ptr_last) begin
          state_next = ledfr_pkg::ST_RESULT;
        end else begin
          ptr_next = ptr_step;
        end
      end

      ledfr_pkg::ST_ROT, ledfr_pkg::ST_DRAIN: begin
        if (state == ledfr_pkg::ST_ROT) begin
          mem_re = 1'b1;
          if (ptr_last) begin
            state_next = ledfr_pkg::ST_DRAIN;
          end else begin
            ptr_next = ptr_step;
          end
        end else begin
          state_next = ledfr_pkg::ST_WRAP;
        end
        if (pipe_cnt == 2'd1) begin
          saved_next = mem_rdata;
        end else if (pipe_cnt == 2'd2) begin
          mem_we    = 1'b1;
          mem_waddr = wp;
          mem_wdata = mem_rdata;
          wp_next   = wp_step;
        end
        if (pipe_cnt != 2'd2) begin
          pipe_cnt_next = pipe_cnt + 2'd1;
        end
      end

      ledfr_pkg::ST_WRAP: begin
        mem_we     = 1'b1;
        mem_waddr  = wp;
        mem_wdata  = saved;
        state_next = ledfr_pkg::ST_RESULT;
      end

      ledfr_pkg::ST_READ: begin
        mem_re     = 1'b1;
        state_next = ledfr_pkg::ST_RESULT;
      end

      ledfr_pkg::ST_RESULT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ledfr_pkg::ST_IDLE;
        end
      end

      default: begin
        state_next = ledfr_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ledfr_pkg::ST_CLEAR;
      ptr       <= '0;
      last      <= AW'(LED_COUNT - 1);
      step_dn   <= 1'b0;
      phase     <= 8'd0;
      out_valid <= 1'b0;
    end else begin
      state   <= state_next;
      ptr     <= ptr_next;
      last    <= last_next;
      step_dn <= step_dn_next;
      phase   <= phase_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    wp         <= wp_next;
    pipe_cnt   <= pipe_cnt_next;
    saved      <= saved_next;
    fill_c     <= fill_c_next;
    res_status <= res_status_next;
    res_read   <= res_read_next;
    if (out_load) begin
      out_word.status      <= res_status;
      out_word.pixel_color <= res_read ? mem_rdata : 24'd0;
    end
  end

endmodule

/* hw/rtl/led_segment_fill_and_rotate_core.sv */
// Items are taken one at a time; the block is not ready while one is at work.
// A fill writes its range, a rotating tick walks its segment and a read fetches one LED
// before the result word is loaded; other words go straight to the result.
// The walks go through the pixel memory one LED per cycle.
// After reset a clearing pass writes zero to all LED_COUNT entries, during which
// no word is accepted; control registers and cfg reset, datapath registers do not.
module led_segment_fill_and_rotate_core #(
  parameter int LED_COUNT = 128
) (
  input  logic                            clk,
  input  logic                            rst,
  ledfr_cmd_if.sink                       cmd,
  ledfr_res_if.source                     res,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ledfr_pkg::PADDR_W-1:0]   paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  localparam int AW = $clog2(LED_COUNT);

  ledfr_pkg::cfg_t      cfg;
  ledfr_pkg::cmd_word_t in_word;
  ledfr_pkg::res_word_t out_word;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [23:0]   mem_wdata;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [23:0]   mem_rdata;
  logic          cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      case (paddr)
        ledfr_pkg::REG_SEG_START:     cfg.seg_start     <= pwdata[6:0];
        ledfr_pkg::REG_SEG_END:       cfg.seg_end       <= pwdata[6:0];
        ledfr_pkg::REG_ROTATE_DIR:    cfg.rotate_dir    <= pwdata[0];
        ledfr_pkg::REG_SPEED_DIV:     cfg.speed_div     <= pwdata[7:0];
        ledfr_pkg::REG_ROTATE_ENABLE: cfg.rotate_enable <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr)
      ledfr_pkg::REG_SEG_START:     prdata = {25'd0, cfg.seg_start};
      ledfr_pkg::REG_SEG_END:       prdata = {25'd0, cfg.seg_end};
      ledfr_pkg::REG_ROTATE_DIR:    prdata = {31'd0, cfg.rotate_dir};
      ledfr_pkg::REG_SPEED_DIV:     prdata = {24'd0, cfg.speed_div};
      ledfr_pkg::REG_ROTATE_ENABLE: prdata = {31'd0, cfg.rotate_enable};
      default:                      prdata = 32'd0;
    endcase
  end

  assign in_word.command     = cmd.command;
  assign in_word.range_start = cmd.range_start;
  assign in_word.range_end   = cmd.range_end;
  assign in_word.fill_color  = cmd.fill_color;
  assign in_word.read_index  = cmd.read_index;

  assign res.status      = out_word.status;
  assign res.pixel_color = out_word.pixel_color;

  ledfr_ctrl #(
    .LED_COUNT(LED_COUNT)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (cmd.valid),
    .in_ready  (cmd.ready),
    .in_word   (in_word),
    .out_valid (res.valid),
    .out_ready (res.ready),
    .out_word  (out_word),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ledfr_pixel_mem #(
    .LED_COUNT(LED_COUNT)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The clearing pass keeps the command channel closed right after reset.
  a_clear_after_reset: assert property (@(posedge clk) rst |=> !cmd.ready)
    else $error("command channel open during clearing pass");

  // Every accepted word leaves the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> !cmd.ready)
    else $error("word accepted while previous word in progress");

  // A rejected fill never carries a pixel color.
  a_status_no_color: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.status) |-> (res.pixel_color == 24'd0))
    else $error("rejected fill returned a nonzero color");

endmodule

/* tb/sv/ledfr_checker.sv */
module ledfr_checker (
  input  logic                          clk,
  input  logic                          rst,
  ledfr_cmd_if                          cmd,
  ledfr_res_if                          res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic                          pready,
  input  logic [ledfr_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output int                            fail_count,
  output int                            words_checked,
  output int                            words_pending
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LEDS = 128;

  logic [23:0]          strip_colors [LEDS];
  logic [7:0]           phase_count;
  ledfr_pkg::cfg_t      strip_cfg;
  ledfr_pkg::res_word_t expected_words [$];

  function automatic logic [7:0] dim_cut(input logic [7:0] chan);
    return (chan < ledfr_pkg::CHAN_FLOOR) ? 8'd0 : chan;
  endfunction

  task automatic shift_segment();
    logic [23:0] saved;
    int lo;
    int hi;
    lo = strip_cfg.seg_start;
    hi = strip_cfg.seg_end;
    if (hi < lo || hi >= LEDS) return;
    if (strip_cfg.rotate_dir) begin
      saved = strip_colors[lo];
      for (int i = lo; i < hi; i++) strip_colors[i] = strip_colors[i + 1];
      strip_colors[hi] = saved;
    end else begin
      saved = strip_colors[hi];
      for (int i = hi; i > lo; i--) strip_colors[i] = strip_colors[i - 1];
      strip_colors[lo] = saved;
    end
  endtask

  task automatic apply_word(input logic [1:0] op, input logic [6:0] rs, input logic [6:0] re,
                            input logic [23:0] color, input logic [6:0] ri,
                            output ledfr_pkg::res_word_t w);
    logic [23:0] fixed;
    w = '0;
    case (op)
      ledfr_pkg::CMD_FILL: begin
        if (rs >= re) begin
          w.status = 1'b1;
        end else begin
          fixed = {dim_cut(color[23:16]), dim_cut(color[15:8]), dim_cut(color[7:0])};
          for (int i = rs; i <= re; i++) strip_colors[i] = fixed;
        end
      end
      ledfr_pkg::CMD_TICK: begin
        if (strip_cfg.rotate_enable) begin
          if (strip_cfg.speed_div == 8'd0 || phase_count == 8'd0) shift_segment();
          if ({1'b0, phase_count} + 9'd1 >= {1'b0, strip_cfg.speed_div}) begin
            phase_count = 8'd0;
          end else begin
            phase_count = phase_count + 8'd1;
          end
        end
      end
      ledfr_pkg::CMD_READ: begin
        w.pixel_color = strip_colors[ri];
      end
      default: begin
      end
    endcase
  endtask

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    fail_count = fail_count + 1;
  endtask

  always @(posedge clk) begin
    ledfr_pkg::res_word_t want;
    ledfr_pkg::res_word_t got;
    if (rst) begin
      for (int i = 0; i < LEDS; i++) strip_colors[i] = '0;
      phase_count = '0;
      strip_cfg = '0;
      expected_words.delete();
      fail_count = 0;
      words_checked <= 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr)
          ledfr_pkg::REG_SEG_START:     strip_cfg.seg_start = pwdata[6:0];
          ledfr_pkg::REG_SEG_END:       strip_cfg.seg_end = pwdata[6:0];
          ledfr_pkg::REG_ROTATE_DIR:    strip_cfg.rotate_dir = pwdata[0];
          ledfr_pkg::REG_SPEED_DIV:     strip_cfg.speed_div = pwdata[7:0];
          ledfr_pkg::REG_ROTATE_ENABLE: strip_cfg.rotate_enable = pwdata[0];
          default: begin
          end
        endcase
      end
      if (cmd.valid && cmd.ready) begin
        apply_word(cmd.command, cmd.range_start, cmd.range_end, cmd.fill_color,
                   cmd.read_index, want);
        expected_words.insert(expected_words.size(), want);
      end
      if (res.valid && res.ready) begin
        got.status = res.status;
        got.pixel_color = res.pixel_color;
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result word %0d arrived with nothing expected",
                                    words_checked));
        end else begin
          want = expected_words.pop_front();
          if (got.status !== want.status) begin
            report_mismatch($sformatf("word %0d status %0b, expected %0b",
                                      words_checked, got.status, want.status));
          end
          if (got.pixel_color !== want.pixel_color) begin
            report_mismatch($sformatf("word %0d pixel_color %06h, expected %06h",
                                      words_checked, got.pixel_color, want.pixel_color));
          end
        end
        words_checked <= words_checked + 1;
      end
    end
    words_pending <= expected_words.size();
  end

endmodule

/* tb/sv/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int PHASES = 6;
  localparam int WORDS_PER_PHASE = 100;

  logic                          clk;
  logic                          rst;
  logic                          psel;
  logic                          penable;
  logic                          pwrite;
  logic [ledfr_pkg::PADDR_W-1:0] paddr;
  logic [31:0]                   pwdata;
  logic [31:0]                   prdata;
  logic                          pready;

  ledfr_cmd_if cmd_ch ();
  ledfr_res_if res_ch ();

  int fail_count;
  int words_checked;
  int words_pending;
  int words_sent;
  int quiet_cycles;
  bit no_idle;

  led_segment_fill_and_rotate_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_ch),
    .res     (res_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  ledfr_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd_ch),
    .res           (res_ch),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .pready        (pready),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .fail_count    (fail_count),
    .words_checked (words_checked),
    .words_pending (words_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [7:0] pick_channel();
    if ($urandom_range(0, 9) < 3) return 8'($urandom_range(0, 7));
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [23:0] pick_color();
    return {pick_channel(), pick_channel(), pick_channel()};
  endfunction

  task automatic cfg_write(input logic [ledfr_pkg::PADDR_W-1:0] addr,
                           input logic [31:0] data);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_strip_cfg(input int seg_lo, input int seg_hi, input int dir,
                               input int speed, input int enable);
    cfg_write(ledfr_pkg::REG_SEG_START, 32'(seg_lo));
    cfg_write(ledfr_pkg::REG_SEG_END, 32'(seg_hi));
    cfg_write(ledfr_pkg::REG_ROTATE_DIR, 32'(dir));
    cfg_write(ledfr_pkg::REG_SPEED_DIV, 32'(speed));
    cfg_write(ledfr_pkg::REG_ROTATE_ENABLE, 32'(enable));
  endtask

  task automatic send_word(input logic [1:0] op, input logic [6:0] rs, input logic [6:0] re,
                           input logic [23:0] color, input logic [6:0] ri);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      if (cmd_ch.valid) cmd_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.command <= op;
    cmd_ch.range_start <= rs;
    cmd_ch.range_end <= re;
    cmd_ch.fill_color <= color;
    cmd_ch.read_index <= ri;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    words_sent++;
  endtask

  task automatic fill_leds(input int rs, input int re, input logic [23:0] color);
    send_word(ledfr_pkg::CMD_FILL, 7'(rs), 7'(re), color, 7'($urandom_range(0, 127)));
  endtask

  task automatic tick_strip();
    send_word(ledfr_pkg::CMD_TICK, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
              24'($urandom_range(0, 24'hFFFFFF)), 7'($urandom_range(0, 127)));
  endtask

  task automatic read_led(input int ri);
    send_word(ledfr_pkg::CMD_READ, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
              24'($urandom_range(0, 24'hFFFFFF)), 7'(ri));
  endtask

  task automatic wait_drained();
    if (cmd_ch.valid) cmd_ch.valid <= 1'b0;
    while (words_checked != words_sent) @(posedge clk);
  endtask

  task automatic random_word();
    int r;
    int rs;
    int re;
    r = $urandom_range(0, 99);
    if (r < 35) begin
      if ($urandom_range(0, 99) < 85) begin
        rs = $urandom_range(0, 126);
        if ($urandom_range(0, 9) < 8) begin
          re = rs + $urandom_range(1, 8);
        end else begin
          re = $urandom_range(rs + 1, 127);
        end
        if (re > 127) re = 127;
      end else begin
        rs = $urandom_range(0, 127);
        re = $urandom_range(0, 127);
      end
      fill_leds(rs, re, pick_color());
    end else if (r < 70) begin
      tick_strip();
    end else if (r < 95) begin
      read_led($urandom_range(0, 127));
    end else begin
      send_word(CMD_UNUSED, 7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)),
                24'($urandom_range(0, 24'hFFFFFF)), 7'($urandom_range(0, 127)));
    end
  endtask

  task automatic run_directed();
    set_strip_cfg(0, 127, 1, 0, 1);
    read_led(0);
    read_led(127);
    fill_leds(0, 127, 24'hFFFFFF);
    fill_leds(5, 5, 24'h00FF00);
    fill_leds(10, 3, 24'hABCDEF);
    fill_leds(0, 1, 24'h040504);
    fill_leds(126, 127, 24'h000000);
    fill_leds(2, 3, 24'h123456);
    tick_strip();
    read_led(0);
    read_led(127);
    read_led(1);
    send_word(CMD_UNUSED, 7'h7F, 7'h7F, 24'hFFFFFF, 7'h7F);
    wait_drained();
    set_strip_cfg(0, 127, 0, 255, 1);
    tick_strip();
    tick_strip();
    read_led(0);
    wait_drained();
    // Lowering the divider to the current phase makes the next tick wrap it.
    set_strip_cfg(10, 5, 1, 2, 1);
    tick_strip();
    tick_strip();
    wait_drained();
    set_strip_cfg(7, 7, 0, 0, 1);
    tick_strip();
    read_led(7);
    wait_drained();
    set_strip_cfg(127, 0, 1, 0, 0);
    tick_strip();
    read_led(0);
  endtask

  task automatic run_random();
    int seg_lo;
    int seg_hi;
    int swap;
    int speed;
    int r;
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      no_idle = ($urandom_range(0, 3) == 0);
      seg_lo = $urandom_range(0, 127);
      seg_hi = $urandom_range(0, 127);
      if (ph == 0) begin
        seg_lo = 0;
        seg_hi = 127;
      end else if (seg_hi < seg_lo && $urandom_range(0, 3) != 0) begin
        swap = seg_lo;
        seg_lo = seg_hi;
        seg_hi = swap;
      end
      r = $urandom_range(0, 9);
      if (r < 4) speed = 0;
      else if (r < 7) speed = $urandom_range(1, 4);
      else if (r < 9) speed = $urandom_range(5, 20);
      else speed = 255;
      set_strip_cfg(seg_lo, seg_hi, $urandom_range(0, 1), speed,
                    ($urandom_range(0, 7) != 0) ? 1 : 0);
      repeat (WORDS_PER_PHASE) random_word();
    end
    no_idle = 1'b0;
  endtask

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.command = '0;
    cmd_ch.range_start = '0;
    cmd_ch.range_end = '0;
    cmd_ch.fill_color = '0;
    cmd_ch.read_index = '0;
    res_ch.ready = 1'b0;
    words_sent = 0;
    no_idle = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    run_directed();
    run_random();
    wait_drained();
    repeat (20) @(posedge clk);
    if (fail_count == 0 && words_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    int gap;
    wait (rst == 1'b0);
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        res_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
      @(posedge clk);
      while (!res_ch.valid) @(posedge clk);
    end
  end

  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (rst || psel || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
      end
    end
    $display("simulation failed");
    $finish;
  end

endmodule
